// ----- hdl/pfr_pkg.sv -----
// Package for the pixel format to RGBA8888 converter.
// Holds format codes, color keys and the stage payload structs.
// No dependencies.
package pfr_pkg;

  typedef enum logic [1:0] {
    FMT_RGB332   = 2'd0,
    FMT_RGB565   = 2'd1,
    FMT_ARGB4444 = 2'd2,
    FMT_ARGB8888 = 2'd3
  } pfr_fmt_e;

  localparam pfr_fmt_e FmtReset = FMT_RGB565;

  localparam logic [7:0]  KeyRgb332 = 8'hC0;
  localparam logic [15:0] KeyRgb565 = 16'hE000;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  // channels left-aligned in 8 bits, low bits zero until expanded
  typedef struct packed {
    pfr_fmt_e   fmt;
    logic       key;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pfr_chan_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pfr_rgba_t;

endpackage

// ----- hdl/pfr_unpack.sv -----
// First pipeline stage: splits the raw pixel word into left-aligned channels
// and flags the color key. Depends on pfr_pkg.
module pfr_unpack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfr_pkg::pfr_fmt_e fmt_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [31:0]       raw_i,
  input  logic              last_i,
  output logic              valid_o,
  input  logic              ready_i,
  output pfr_pkg::pfr_chan_t chan_o
);
  import pfr_pkg::*;

  logic      valid_q;
  pfr_chan_t chan_d, chan_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    chan_d      = '0;
    chan_d.fmt  = fmt_i;
    chan_d.last = last_i;
    chan_d.a    = AlphaOpaque;
    case (fmt_i)
      FMT_RGB332: begin
        chan_d.key = (raw_i[7:0] == KeyRgb332);
        chan_d.r   = {raw_i[7:5], 5'd0};
        chan_d.g   = {raw_i[4:2], 5'd0};
        chan_d.b   = {raw_i[1:0], 6'd0};
      end
      FMT_RGB565: begin
        chan_d.key = (raw_i[15:0] == KeyRgb565);
        chan_d.r   = {raw_i[15:11], 3'd0};
        chan_d.g   = {raw_i[10:5], 2'd0};
        chan_d.b   = {raw_i[4:0], 3'd0};
      end
      FMT_ARGB4444: begin
        chan_d.r = {raw_i[11:8], 4'd0};
        chan_d.g = {raw_i[7:4], 4'd0};
        chan_d.b = {raw_i[3:0], 4'd0};
      end
      default: begin
        chan_d.b = raw_i[7:0];
        chan_d.g = raw_i[15:8];
        chan_d.r = raw_i[23:16];
        chan_d.a = raw_i[31:24];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      chan_q <= chan_d;
    end
  end

  assign valid_o = valid_q;
  assign chan_o  = chan_q;

endmodule

// ----- hdl/pfr_expand.sv -----
// Second pipeline stage: widens channels to 8 bits by bit replication and
// applies the color key. Depends on pfr_pkg.
module pfr_expand (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  pfr_pkg::pfr_chan_t chan_i,
  output logic               valid_o,
  input  logic               ready_i,
  output pfr_pkg::pfr_rgba_t pix_o
);
  import pfr_pkg::*;

  logic      valid_q;
  pfr_rgba_t pix_d, pix_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    pix_d      = '0;
    pix_d.last = chan_i.last;
    pix_d.a    = chan_i.a;
    case (chan_i.fmt)
      FMT_RGB332: begin
        pix_d.r = {chan_i.r[7:5], chan_i.r[7:5], chan_i.r[7:6]};
        pix_d.g = {chan_i.g[7:5], chan_i.g[7:5], chan_i.g[7:6]};
        pix_d.b = {4{chan_i.b[7:6]}};
      end
      FMT_RGB565: begin
        pix_d.r = {chan_i.r[7:3], chan_i.r[7:5]};
        pix_d.g = {chan_i.g[7:2], chan_i.g[7:6]};
        pix_d.b = {chan_i.b[7:3], chan_i.b[7:5]};
      end
      FMT_ARGB4444: begin
        pix_d.r = {chan_i.r[7:4], chan_i.r[7:4]};
        pix_d.g = {chan_i.g[7:4], chan_i.g[7:4]};
        pix_d.b = {chan_i.b[7:4], chan_i.b[7:4]};
      end
      default: begin
        pix_d.r = chan_i.r;
        pix_d.g = chan_i.g;
        pix_d.b = chan_i.b;
      end
    endcase
    if (chan_i.key) begin
      pix_d.r = '0;
      pix_d.g = '0;
      pix_d.b = '0;
      pix_d.a = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  a_key_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && chan_i.key |=> pix_q.r == '0 && pix_q.a == '0)
    else $error("keyed pixel not cleared");

  a_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o && !chan_i.key && chan_i.fmt != FMT_ARGB8888
    |=> pix_q.a == AlphaOpaque)
    else $error("narrow format pixel not opaque");

endmodule

// ----- hdl/pixel_format_to_rgba8888_core.sv -----
// Top level of the pixel format to RGBA8888 converter.
// Depends on pfr_pkg, pfr_unpack and pfr_expand.
//
// Usage:
//   s_axis carries one raw pixel word per beat in tdata, tlast marks the
//   last pixel of an image. m_axis returns one RGBA8888 beat per input
//   beat, in order, with tlast copied through.
//   The cfg channel writes the 2-bit format register (0 RGB332, 1 RGB565,
//   2 ARGB4444, 3 ARGB8888); it is always ready. Write it only while the
//   pipeline is empty.
//   Throughput is one pixel per clock while m_axis_tready stays high; three
//   registered stages (unpack, expand, output) each hold one beat, and each
//   stage takes a new beat whenever it is empty or its own beat leaves in
//   the same cycle.
//   Reset empties all stages and sets the format to RGB565.
//   When m_axis_tready is low the stages fill up; once all three hold a
//   beat s_axis_tready drops, and nothing is lost or repeated.
module pixel_format_to_rgba8888_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,    // pixel_format
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // raw_pixel[31:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic        m_axis_tlast
);
  import pfr_pkg::*;

  pfr_fmt_e  fmt_q;
  logic      unp_valid, unp_ready;
  pfr_chan_t unp_chan;
  logic      exp_valid, exp_ready;
  pfr_rgba_t exp_pix;
  logic      out_valid_q;
  pfr_rgba_t out_pix_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtReset;
    end else if (cfg_valid_i) begin
      fmt_q <= pfr_fmt_e'(cfg_data_i);
    end
  end

  pfr_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (fmt_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .raw_i   (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .valid_o (unp_valid),
    .ready_i (unp_ready),
    .chan_o  (unp_chan)
  );

  pfr_expand u_expand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (unp_valid),
    .ready_o (unp_ready),
    .chan_i  (unp_chan),
    .valid_o (exp_valid),
    .ready_i (exp_ready),
    .pix_o   (exp_pix)
  );

  // output stage
  assign exp_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exp_ready) begin
      out_valid_q <= exp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exp_valid && exp_ready) begin
      out_pix_q <= exp_pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_pix_q.a, out_pix_q.b, out_pix_q.g, out_pix_q.r};
  assign m_axis_tlast  = out_pix_q.last;

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> out_valid_q && exp_valid && unp_valid)
    else $error("input stalled with an empty stage");

endmodule

// ----- test/pixel_format_to_rgba8888_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for pixel_format_to_rgba8888_core: directed and random pixel beats in all four
// input formats, with random idling on both streams; output beats checked in order.
// Depends on pfr_pkg and the core RTL.
module pixel_format_to_rgba8888_core_tb;
  import pfr_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxGap = 14;
  localparam int unsigned RandomPixels = 950;
  localparam int unsigned PausePixels = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  pfr_fmt_e    active_fmt = FmtReset;
  pfr_rgba_t   pending_pixels[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned pixels_sent = 0;
  bit          no_gaps = 1'b0;

  pixel_format_to_rgba8888_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic pfr_rgba_t expand_pixel(input pfr_fmt_e fmt, input logic [31:0] raw,
                                             input logic last);
    pfr_rgba_t px;
    px.a = AlphaOpaque;
    px.last = last;
    case (fmt)
      FMT_RGB332: begin
        px.r = {raw[7:5], raw[7:5], raw[7:6]};
        px.g = {raw[4:2], raw[4:2], raw[4:3]};
        px.b = {4{raw[1:0]}};
        if (raw[7:0] == KeyRgb332) begin
          px.r = 8'd0; px.g = 8'd0; px.b = 8'd0; px.a = 8'd0;
        end
      end
      FMT_RGB565: begin
        px.r = {raw[15:11], raw[15:13]};
        px.g = {raw[10:5], raw[10:9]};
        px.b = {raw[4:0], raw[4:2]};
        if (raw[15:0] == KeyRgb565) begin
          px.r = 8'd0; px.g = 8'd0; px.b = 8'd0; px.a = 8'd0;
        end
      end
      FMT_ARGB4444: begin
        px.r = {2{raw[11:8]}};
        px.g = {2{raw[7:4]}};
        px.b = {2{raw[3:0]}};
      end
      default: begin
        px.r = raw[23:16];
        px.g = raw[15:8];
        px.b = raw[7:0];
        px.a = raw[31:24];
      end
    endcase
    return px;
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [31:0] random_raw();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 7))
      0: raw[7:0] = KeyRgb332;
      1: raw[15:0] = KeyRgb565;
      default: ;
    endcase
    return raw;
  endfunction

  task automatic send_pixel(input logic [31:0] raw, input logic last);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = raw;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(expand_pixel(active_fmt, raw, last));
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(random_raw(), $urandom_range(0, 7) == 0);
  endtask

  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_format(input pfr_fmt_e fmt);
    drain_pixels();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = fmt;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_fmt = fmt;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endtask

  initial begin : result_monitor
    pfr_rgba_t   want;
    int unsigned stall;
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_pixels.size() == 0) begin
        $error("output beat with nothing pending: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("red", want.r, m_axis_tdata[7:0]);
        compare_field("green", want.g, m_axis_tdata[15:8]);
        compare_field("blue", want.b, m_axis_tdata[23:16]);
        compare_field("alpha", want.a, m_axis_tdata[31:24]);
        compare_field("end_of_image", {7'd0, want.last}, {7'd0, m_axis_tlast});
      end
    end
  end

  // format register left at its reset value
  task automatic test_reset_format();
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_FFFF, 1'b1);
    send_pixel(32'h0000_E000, 1'b0);
    send_pixel(32'hFFFF_E000, 1'b1);
    send_pixel(32'hA5A5_F81F, 1'b0);
    send_pixel(32'h0000_07E0, 1'b0);
  endtask

  task automatic test_rgb332();
    write_format(FMT_RGB332);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_00FF, 1'b1);
    send_pixel(32'h0000_00C0, 1'b0);
    send_pixel(32'hFFFF_FFC0, 1'b0);
    send_pixel(32'h0000_00E0, 1'b0);
    send_pixel(32'h0000_001C, 1'b0);
    send_pixel(32'hFFFF_FF03, 1'b1);
  endtask

  task automatic test_argb4444();
    write_format(FMT_ARGB4444);
    send_pixel(32'h0000_F000, 1'b0);
    send_pixel(32'h0000_0FFF, 1'b1);
    send_pixel(32'hFFFF_0000, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
  endtask

  task automatic test_argb8888();
    write_format(FMT_ARGB8888);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h00FF_00FF, 1'b0);
    send_pixel(32'hC0E0_C0E0, 1'b1);
  endtask

  // stop the sender until the pipeline is empty, then restart at full rate
  task automatic test_drain_pause();
    write_format(FMT_RGB565);
    repeat (PausePixels) send_random_pixel();
    drain_pixels();
    no_gaps = 1'b1;
    repeat (PausePixels) send_random_pixel();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_formats();
    int unsigned stop_at;
    int unsigned phase;
    int unsigned len;
    pfr_fmt_e    fmt;
    stop_at = pixels_sent + RandomPixels - 2 * PausePixels;
    phase = 0;
    while (pixels_sent < stop_at) begin
      fmt = (phase < 4) ? pfr_fmt_e'(2'(3 - phase)) : pfr_fmt_e'(2'($urandom_range(0, 3)));
      write_format(fmt);
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(30, 110);
      repeat (len) begin
        if (pixels_sent < stop_at) begin
          send_random_pixel();
          if ($urandom_range(0, 99) == 0) drain_pixels();
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_format();
    test_rgb332();
    test_argb4444();
    test_argb8888();
    test_drain_pause();
    test_random_formats();
    drain_pixels();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
